// File: rtl/core/ahht_pkg.sv
package ahht_pkg;

  localparam int COORD_BITS_DEF = 20;
  localparam int RADIUS_BITS    = 41;
  localparam int RAD_LO_BITS    = 21;
  localparam int CFG_IDX_BITS   = 3;
  localparam int OUT_TDATA_W    = 8;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RST = RADIUS_BITS'(6400);

  typedef enum logic [2:0] {
    AREA_NONE     = 3'd0,
    AREA_ARM1_END = 3'd1,
    AREA_ARM2_END = 3'd2,
    AREA_VERTEX   = 3'd3,
    AREA_ARM1     = 3'd4,
    AREA_ARM2     = 3'd5
  } area_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_VERTEX_X      = 3'd0,
    CFG_VERTEX_Y      = 3'd1,
    CFG_ARM1_END_X    = 3'd2,
    CFG_ARM1_END_Y    = 3'd3,
    CFG_ARM2_END_X    = 3'd4,
    CFG_ARM2_END_Y    = 3'd5,
    CFG_HIT_RADIUS_SQ = 3'd6
  } cfg_idx_e;

endpackage

// File: rtl/core/angle_handle_hit_test_unit.sv
// Hit test of one query point against an angle figure (vertex plus two arm
// end points) held in configuration registers. Tests in priority order: arm1
// end, arm2 end, vertex, segment vertex-arm1, segment vertex-arm2; the first
// one within the squared radius gives the area code, 0 when none, with hit set
// for any area. Exact integer arithmetic throughout. Six register stages: one
// item enters per cycle; a stall on the output holds the whole pipeline. The
// user must write configuration only while idle; the block does not enforce
// this. Derived values settle through the arm-vector, square and sum registers.
module angle_handle_hit_test_unit
  import ahht_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // query_x, query_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]          s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // area[2:0], hit[3]
  output logic [OUT_TDATA_W-1:0]                     m_axis_tdata,
  input  logic                                       cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]                    cfg_idx_i,
  input  logic [RADIUS_BITS-1:0]                     cfg_data_i
);

  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;
  localparam int PW   = 2 * C + 2;
  localparam int SW   = PW;
  localparam int TW   = SW + 1;
  localparam int CMPW = (SW > RADIUS_BITS) ? SW : RADIUS_BITS;

  // configuration
  logic signed [C-1:0]    vx_q, vy_q, e1x_q, e1y_q, e2x_q, e2y_q;
  logic [RADIUS_BITS-1:0] rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q  <= '0;
      vy_q  <= '0;
      e1x_q <= '0;
      e1y_q <= '0;
      e2x_q <= '0;
      e2y_q <= '0;
      rad_q <= RADIUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_VERTEX_X:      vx_q  <= cfg_data_i[C-1:0];
        CFG_VERTEX_Y:      vy_q  <= cfg_data_i[C-1:0];
        CFG_ARM1_END_X:    e1x_q <= cfg_data_i[C-1:0];
        CFG_ARM1_END_Y:    e1y_q <= cfg_data_i[C-1:0];
        CFG_ARM2_END_X:    e2x_q <= cfg_data_i[C-1:0];
        CFG_ARM2_END_Y:    e2y_q <= cfg_data_i[C-1:0];
        CFG_HIT_RADIUS_SQ: rad_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // figure-derived values: arm vectors and squared arm lengths
  logic signed [DW-1:0] d1x_q, d1y_q, d2x_q, d2y_q;
  logic [PW-1:0]        l1x_q, l1y_q, l2x_q, l2y_q;
  logic [SW-1:0]        len1_q, len2_q;

  always_ff @(posedge clk_i) begin
    d1x_q  <= DW'(e1x_q) - DW'(vx_q);
    d1y_q  <= DW'(e1y_q) - DW'(vy_q);
    d2x_q  <= DW'(e2x_q) - DW'(vx_q);
    d2y_q  <= DW'(e2y_q) - DW'(vy_q);
    l1x_q  <= PW'(d1x_q) * PW'(d1x_q);
    l1y_q  <= PW'(d1y_q) * PW'(d1y_q);
    l2x_q  <= PW'(d2x_q) * PW'(d2x_q);
    l2y_q  <= PW'(d2y_q) * PW'(d2y_q);
    len1_q <= l1x_q + l1y_q;
    len2_q <= l2x_q + l2y_q;
  end

  // pipeline control
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;

  assign adv           = ~vo_q | m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      vo_q <= v5_q;
    end
  end

  // stage 1: offsets of the query from each figure point
  logic signed [C-1:0]  qx, qy;
  logic signed [DW-1:0] a1x_q, a1y_q, a2x_q, a2y_q, wx_q, wy_q;

  assign qx = s_axis_tdata[C-1:0];
  assign qy = s_axis_tdata[2*C-1:C];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1x_q <= DW'(qx) - DW'(e1x_q);
      a1y_q <= DW'(qy) - DW'(e1y_q);
      a2x_q <= DW'(qx) - DW'(e2x_q);
      a2y_q <= DW'(qy) - DW'(e2y_q);
      wx_q  <= DW'(qx) - DW'(vx_q);
      wy_q  <= DW'(qy) - DW'(vy_q);
    end
  end

  // stage 2: products
  logic [PW-1:0]        s1x_q, s1y_q, s2x_q, s2y_q, svx_q, svy_q;
  logic signed [PW-1:0] t1a_q, t1b_q, t2a_q, t2b_q;
  logic signed [PW-1:0] c1a_q, c1b_q, c2a_q, c2b_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1x_q <= PW'(a1x_q) * PW'(a1x_q);
      s1y_q <= PW'(a1y_q) * PW'(a1y_q);
      s2x_q <= PW'(a2x_q) * PW'(a2x_q);
      s2y_q <= PW'(a2y_q) * PW'(a2y_q);
      svx_q <= PW'(wx_q) * PW'(wx_q);
      svy_q <= PW'(wy_q) * PW'(wy_q);
      t1a_q <= PW'(wx_q) * PW'(d1x_q);
      t1b_q <= PW'(wy_q) * PW'(d1y_q);
      t2a_q <= PW'(wx_q) * PW'(d2x_q);
      t2b_q <= PW'(wy_q) * PW'(d2y_q);
      c1a_q <= PW'(wx_q) * PW'(d1y_q);
      c1b_q <= PW'(wy_q) * PW'(d1x_q);
      c2a_q <= PW'(wx_q) * PW'(d2y_q);
      c2b_q <= PW'(wy_q) * PW'(d2x_q);
    end
  end

  // stage 3: squared distances, projections, cross magnitudes
  logic signed [TW-1:0] c1ab, c1ba, c2ab, c2ba;
  logic [SW-1:0]        de1_q, de2_q, dv_q, m1_q, m2_q;
  logic signed [TW-1:0] t1_q, t2_q;

  assign c1ab = TW'(c1a_q) - TW'(c1b_q);
  assign c1ba = TW'(c1b_q) - TW'(c1a_q);
  assign c2ab = TW'(c2a_q) - TW'(c2b_q);
  assign c2ba = TW'(c2b_q) - TW'(c2a_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      de1_q <= s1x_q + s1y_q;
      de2_q <= s2x_q + s2y_q;
      dv_q  <= svx_q + svy_q;
      t1_q  <= TW'(t1a_q) + TW'(t1b_q);
      t2_q  <= TW'(t2a_q) + TW'(t2b_q);
      m1_q  <= c1ab[TW-1] ? SW'(c1ba) : SW'(c1ab);
      m2_q  <= c2ab[TW-1] ? SW'(c2ba) : SW'(c2ab);
    end
  end

  // stage 4: endpoint hits and segment case selection
  logic h1, h2, hv;
  logic seg1_pt, seg1_res, seg2_pt, seg2_res;
  logic h1_q, h2_q, hv_q, seg1_pt_q, seg1_res_q, seg2_pt_q, seg2_res_q;

  assign h1 = CMPW'(de1_q) <= CMPW'(rad_q);
  assign h2 = CMPW'(de2_q) <= CMPW'(rad_q);
  assign hv = CMPW'(dv_q)  <= CMPW'(rad_q);

  always_comb begin
    seg1_pt  = 1'b1;
    seg1_res = 1'b0;
    priority if (len1_q == '0) begin
      seg1_res = h1;
    end else if (t1_q[TW-1] || t1_q == '0) begin
      seg1_res = hv;
    end else if (t1_q >= $signed({1'b0, len1_q})) begin
      seg1_res = h1;
    end else begin
      seg1_pt = 1'b0;
    end
    seg2_pt  = 1'b1;
    seg2_res = 1'b0;
    priority if (len2_q == '0) begin
      seg2_res = h2;
    end else if (t2_q[TW-1] || t2_q == '0) begin
      seg2_res = hv;
    end else if (t2_q >= $signed({1'b0, len2_q})) begin
      seg2_res = h2;
    end else begin
      seg2_pt = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h1_q       <= h1;
      h2_q       <= h2;
      hv_q       <= hv;
      seg1_pt_q  <= seg1_pt;
      seg1_res_q <= seg1_res;
      seg2_pt_q  <= seg2_pt;
      seg2_res_q <= seg2_res;
    end
  end

  // stages 4 and 5 of the interior test: cross^2 <= r * len
  logic le1, le2;

  ahht_cross_cmp #(
    .COORD_BITS(COORD_BITS)
  ) u_cmp1 (
    .clk_i    (clk_i),
    .en_i     (adv),
    .mag_i    (m1_q),
    .len_i    (len1_q),
    .radius_i (rad_q),
    .le_o     (le1)
  );

  ahht_cross_cmp #(
    .COORD_BITS(COORD_BITS)
  ) u_cmp2 (
    .clk_i    (clk_i),
    .en_i     (adv),
    .mag_i    (m2_q),
    .len_i    (len2_q),
    .radius_i (rad_q),
    .le_o     (le2)
  );

  // stage 5: flags delayed to meet the wide products
  logic h1_5q, h2_5q, hv_5q, seg1_pt_5q, seg1_res_5q, seg2_pt_5q, seg2_res_5q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h1_5q       <= h1_q;
      h2_5q       <= h2_q;
      hv_5q       <= hv_q;
      seg1_pt_5q  <= seg1_pt_q;
      seg1_res_5q <= seg1_res_q;
      seg2_pt_5q  <= seg2_pt_q;
      seg2_res_5q <= seg2_res_q;
    end
  end

  // stage 6: priority select into the output register
  logic  seg1_hit, seg2_hit;
  area_e area_d, area_q;

  assign seg1_hit = seg1_pt_5q ? seg1_res_5q : le1;
  assign seg2_hit = seg2_pt_5q ? seg2_res_5q : le2;

  always_comb begin
    priority if (h1_5q) begin
      area_d = AREA_ARM1_END;
    end else if (h2_5q) begin
      area_d = AREA_ARM2_END;
    end else if (hv_5q) begin
      area_d = AREA_VERTEX;
    end else if (seg1_hit) begin
      area_d = AREA_ARM1;
    end else if (seg2_hit) begin
      area_d = AREA_ARM2;
    end else begin
      area_d = AREA_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      area_q <= area_d;
    end
  end

  assign m_axis_tdata = {(OUT_TDATA_W-4)'(0), area_q != AREA_NONE, area_q};

endmodule

// File: rtl/core/ahht_cross_cmp.sv
module ahht_cross_cmp
  import ahht_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [2*COORD_BITS+1:0]      mag_i,
  input  logic [2*COORD_BITS+1:0]      len_i,
  input  logic [RADIUS_BITS-1:0]       radius_i,
  output logic                         le_o
);

  localparam int H   = COORD_BITS + 1;
  localparam int RHB = RADIUS_BITS - RAD_LO_BITS;
  localparam int CW  = (4 * H > RADIUS_BITS + 2 * H) ? 4 * H : RADIUS_BITS + 2 * H;

  logic [H-1:0]           mh, ml, lh, ll;
  logic [RAD_LO_BITS-1:0] rlo;
  logic [RHB-1:0]         rhi;

  // partial products
  logic [2*H-1:0]             mhh_q, mhl_q, mll_q;
  logic [RAD_LO_BITS+H-1:0]   rll_q, rlh_q;
  logic [RHB+H-1:0]           rhl_q, rhh_q;
  // full products
  logic [CW-1:0]              csq_d, csq_q, rlen_d, rlen_q;

  assign mh  = mag_i[2*H-1:H];
  assign ml  = mag_i[H-1:0];
  assign lh  = len_i[2*H-1:H];
  assign ll  = len_i[H-1:0];
  assign rlo = radius_i[RAD_LO_BITS-1:0];
  assign rhi = radius_i[RADIUS_BITS-1:RAD_LO_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mhh_q <= (2*H)'(mh) * (2*H)'(mh);
      mhl_q <= (2*H)'(mh) * (2*H)'(ml);
      mll_q <= (2*H)'(ml) * (2*H)'(ml);
      rll_q <= (RAD_LO_BITS+H)'(rlo) * (RAD_LO_BITS+H)'(ll);
      rlh_q <= (RAD_LO_BITS+H)'(rlo) * (RAD_LO_BITS+H)'(lh);
      rhl_q <= (RHB+H)'(rhi) * (RHB+H)'(ll);
      rhh_q <= (RHB+H)'(rhi) * (RHB+H)'(lh);
    end
  end

  assign csq_d  = (CW'(mhh_q) << (2*H)) + (CW'(mhl_q) << (H+1)) + CW'(mll_q);
  assign rlen_d = (CW'(rhh_q) << (RAD_LO_BITS+H)) + (CW'(rlh_q) << H)
                + (CW'(rhl_q) << RAD_LO_BITS) + CW'(rll_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      csq_q  <= csq_d;
      rlen_q <= rlen_d;
    end
  end

  assign le_o = (csq_q <= rlen_q);

endmodule
